@@ src/prqs_pkg.sv @@
// Shared types and constants of the priority ready-queue scheduler.
package prqs_pkg;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_TAKE    = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2
  } status_e;

  localparam int FIND_WIDTH  = 32;
  localparam int FIND_STEPS  = 5;
  localparam int FIND_STEP_W = $clog2(FIND_STEPS);
  localparam int FIND_POS_W  = $clog2(FIND_WIDTH);

  localparam logic [FIND_WIDTH-1:0] FIND_MASKS [FIND_STEPS] = '{
    32'hffff0000, 32'h0000ff00, 32'h000000f0, 32'h0000000c, 32'h00000002
  };

  localparam logic [FIND_POS_W-1:0] FIND_SHIFTS [FIND_STEPS] = '{
    5'd16, 5'd8, 5'd4, 5'd2, 5'd1
  };

endpackage

@@ src/prqs_ram.sv @@
// Single write port, single read port RAM with registered read data.
module prqs_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/prqs_top_find.sv @@
// Iterative highest-set-bit search, one halving step per cycle.
module prqs_top_find (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [prqs_pkg::FIND_WIDTH-1:0]      mask_i,
  output logic                                 done_o,
  output logic [prqs_pkg::FIND_POS_W-1:0]      level_o
);

  logic                                run_q, run_d;
  logic                                done_q, done_d;
  logic [prqs_pkg::FIND_STEP_W-1:0]    step_q, step_d;
  logic [prqs_pkg::FIND_WIDTH-1:0]     m_q, m_d;
  logic [prqs_pkg::FIND_POS_W-1:0]     p_q, p_d;
  logic                                hit;
  logic                                last;

  always_comb begin
    hit    = |(m_q & prqs_pkg::FIND_MASKS[step_q]);
    last   = step_q == prqs_pkg::FIND_STEP_W'(prqs_pkg::FIND_STEPS - 1);
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    m_d    = m_q;
    p_d    = p_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      m_d    = mask_i;
      p_d    = '0;
    end else if (run_q) begin
      if (hit) begin
        m_d = m_q >> prqs_pkg::FIND_SHIFTS[step_q];
        p_d = p_q + prqs_pkg::FIND_SHIFTS[step_q];
      end
      step_d = step_q + prqs_pkg::FIND_STEP_W'(1);
      if (last) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    p_q <= p_d;
  end

  assign done_o  = done_q;
  assign level_o = p_q;

endmodule

@@ src/priority_ready_queue_scheduler_unit.sv @@
// Priority ready-queue scheduler: per-level linked FIFOs over task slots.
// Refused or empty beats go straight to the reply; remove reads the node links, then
// unlinks; enqueue reads head and tail, links, finishes; take runs five steps of the
// priority search plus two link RAM reads. A new beat is taken only while idle.
// Reset clears the sequencer, queued bits, level mask and count; link RAMs are not
// cleared, their entries are used only behind a set queued bit or level mask bit.
module priority_ready_queue_scheduler_unit #(
  parameter int SLOTS  = 32,
  parameter int LEVELS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  command_i,
  input  logic [4:0]  slot_i,
  input  logic [4:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [4:0]  picked_slot_o,
  output logic [4:0]  picked_priority_o,
  output logic [31:0] ready_mask_o,
  output logic [5:0]  ready_total_o
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(LEVELS);
  localparam int CW = $clog2(SLOTS + 1);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_ENQ_RD   = 10'b0000000010,
    S_ENQ_LINK = 10'b0000000100,
    S_ENQ_FIN  = 10'b0000001000,
    S_RM_RD    = 10'b0000010000,
    S_FIND     = 10'b0000100000,
    S_HEAD_RD  = 10'b0001000000,
    S_NODE_RD  = 10'b0010000000,
    S_UNLINK   = 10'b0100000000,
    S_REPLY    = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic [SLOTS-1:0]      queued_q, queued_d;
  logic [LEVELS-1:0]     mask_q, mask_d;
  logic [CW-1:0]         count_q, count_d;

  prqs_pkg::cmd_e        cmd_q, cmd_d;
  logic [SW-1:0]         slot_q, slot_d;
  logic [LW-1:0]         pr_q, pr_d;
  prqs_pkg::status_e     reply_q, reply_d;
  prqs_pkg::status_e     out_status_q, out_status_d;
  logic [4:0]            out_slot_q, out_slot_d;
  logic [4:0]            out_pr_q, out_pr_d;

  logic                  out_free;
  logic                  out_load;
  logic                  slot_ok;
  logic                  prio_ok;
  logic                  slot_busy;
  prqs_pkg::cmd_e        in_cmd;

  logic                  find_start;
  logic                  find_done;
  logic [prqs_pkg::FIND_POS_W-1:0] find_level;

  logic [SW-1:0]         node_raddr;
  logic [LW-1:0]         lvl_raddr;
  logic [SW:0]           next_rd, prev_rd, head_rd, tail_rd;
  logic [LW-1:0]         lvl_rd;
  logic [SW:0]           tail_link;

  logic                  next_we, prev_we, lvl_we, head_we, tail_we;
  logic [SW-1:0]         next_waddr, prev_waddr, lvl_waddr;
  logic [LW-1:0]         head_waddr, tail_waddr;
  logic [SW:0]           next_wdata, prev_wdata, head_wdata, tail_wdata;
  logic [LW-1:0]         lvl_wdata;

  assign in_cmd    = prqs_pkg::cmd_e'(command_i);
  assign slot_ok   = int'(slot_i) < SLOTS;
  assign prio_ok   = int'(priority_req_i) < LEVELS;
  assign slot_busy = slot_ok && queued_q[SW'(slot_i)];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign tail_link = mask_q[pr_q] ? tail_rd : '0;

  assign node_raddr = (state_q == S_NODE_RD) ? head_rd[SW-1:0] : slot_q;
  assign lvl_raddr  = (state_q == S_ENQ_RD) ? pr_q : LW'(find_level);

  always_comb begin
    state_d      = state_q;
    queued_d     = queued_q;
    mask_d       = mask_q;
    count_d      = count_q;
    cmd_d        = cmd_q;
    slot_d       = slot_q;
    pr_d         = pr_q;
    reply_d      = reply_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_pr_d     = out_pr_q;
    out_load     = 1'b0;
    find_start   = 1'b0;

    next_we    = 1'b0;
    next_waddr = slot_q;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = slot_q;
    prev_wdata = '0;
    lvl_we     = 1'b0;
    lvl_waddr  = slot_q;
    lvl_wdata  = pr_q;
    head_we    = 1'b0;
    head_waddr = pr_q;
    head_wdata = '0;
    tail_we    = 1'b0;
    tail_waddr = pr_q;
    tail_wdata = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_cmd;
          slot_d  = SW'(slot_i);
          pr_d    = LW'(priority_req_i);
          reply_d = prqs_pkg::ST_INVALID;
          state_d = S_REPLY;
          case (in_cmd)
            prqs_pkg::CMD_ENQUEUE: begin
              if (slot_ok && prio_ok && !slot_busy) begin
                state_d = S_ENQ_RD;
              end
            end
            prqs_pkg::CMD_REMOVE: begin
              if (slot_busy) begin
                state_d = S_RM_RD;
              end
            end
            prqs_pkg::CMD_TAKE: begin
              if (mask_q != '0) begin
                find_start = 1'b1;
                state_d    = S_FIND;
              end else begin
                reply_d = prqs_pkg::ST_EMPTY;
              end
            end
            default: begin
              reply_d = prqs_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_ENQ_RD: begin
        state_d = S_ENQ_LINK;
      end
      S_ENQ_LINK: begin
        next_we    = tail_link[SW];
        next_waddr = tail_link[SW-1:0];
        next_wdata = {1'b1, slot_q};
        head_we    = !tail_link[SW];
        head_waddr = pr_q;
        head_wdata = {1'b1, slot_q};
        prev_we    = 1'b1;
        prev_waddr = slot_q;
        prev_wdata = tail_link;
        tail_we    = 1'b1;
        tail_waddr = pr_q;
        tail_wdata = {1'b1, slot_q};
        state_d    = S_ENQ_FIN;
      end
      S_ENQ_FIN: begin
        if (out_free) begin
          next_we          = 1'b1;
          next_waddr       = slot_q;
          next_wdata       = '0;
          lvl_we           = 1'b1;
          lvl_waddr        = slot_q;
          lvl_wdata        = pr_q;
          queued_d[slot_q] = 1'b1;
          mask_d[pr_q]     = 1'b1;
          count_d          = count_q + CW'(1);
          out_load         = 1'b1;
          out_status_d     = prqs_pkg::ST_OK;
          out_slot_d       = '0;
          out_pr_d         = '0;
          state_d          = S_IDLE;
        end
      end
      S_RM_RD: begin
        state_d = S_UNLINK;
      end
      S_FIND: begin
        if (find_done) begin
          state_d = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        state_d = S_NODE_RD;
      end
      S_NODE_RD: begin
        slot_d  = head_rd[SW-1:0];
        state_d = S_UNLINK;
      end
      S_UNLINK: begin
        if (out_free) begin
          next_we          = prev_rd[SW];
          next_waddr       = prev_rd[SW-1:0];
          next_wdata       = next_rd;
          head_we          = !prev_rd[SW];
          head_waddr       = lvl_rd;
          head_wdata       = next_rd;
          prev_we          = next_rd[SW];
          prev_waddr       = next_rd[SW-1:0];
          prev_wdata       = prev_rd;
          tail_we          = !next_rd[SW];
          tail_waddr       = lvl_rd;
          tail_wdata       = prev_rd;
          queued_d[slot_q] = 1'b0;
          count_d          = count_q - CW'(1);
          if (!prev_rd[SW] && !next_rd[SW]) begin
            mask_d[lvl_rd] = 1'b0;
          end
          out_load     = 1'b1;
          out_status_d = prqs_pkg::ST_OK;
          out_slot_d   = (cmd_q == prqs_pkg::CMD_TAKE) ? 5'(slot_q) : '0;
          out_pr_d     = (cmd_q == prqs_pkg::CMD_TAKE) ? 5'(lvl_rd) : '0;
          state_d      = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = reply_q;
          out_slot_d   = '0;
          out_pr_d     = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      queued_q    <= '0;
      mask_q      <= '0;
      count_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      queued_q    <= queued_d;
      mask_q      <= mask_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    slot_q       <= slot_d;
    pr_q         <= pr_d;
    reply_q      <= reply_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_pr_q     <= out_pr_d;
  end

  prqs_top_find u_find (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (find_start),
    .mask_i  (prqs_pkg::FIND_WIDTH'(mask_q)),
    .done_o  (find_done),
    .level_o (find_level)
  );

  prqs_ram #(.WIDTH(SW + 1), .DEPTH(SLOTS)) u_next_ram (
    .clk_i   (clk_i),
    .we_i    (next_we),
    .waddr_i (next_waddr),
    .wdata_i (next_wdata),
    .raddr_i (node_raddr),
    .rdata_o (next_rd)
  );

  prqs_ram #(.WIDTH(SW + 1), .DEPTH(SLOTS)) u_prev_ram (
    .clk_i   (clk_i),
    .we_i    (prev_we),
    .waddr_i (prev_waddr),
    .wdata_i (prev_wdata),
    .raddr_i (node_raddr),
    .rdata_o (prev_rd)
  );

  prqs_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (lvl_waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (node_raddr),
    .rdata_o (lvl_rd)
  );

  prqs_ram #(.WIDTH(SW + 1), .DEPTH(LEVELS)) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (head_rd)
  );

  prqs_ram #(.WIDTH(SW + 1), .DEPTH(LEVELS)) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (tail_waddr),
    .wdata_i (tail_wdata),
    .raddr_i (lvl_raddr),
    .rdata_o (tail_rd)
  );

  assign in_stall_o        = state_q != S_IDLE;
  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign picked_slot_o     = out_slot_q;
  assign picked_priority_o = out_pr_q;
  assign ready_mask_o      = 32'(mask_q);
  assign ready_total_o     = 6'(count_q);

endmodule
